### src/wct_pkg.sv
// Shared constants and widths for the window change trigger.
package wct_pkg;

  localparam int WINDOW    = 10;
  localparam int HALF      = WINDOW / 2;
  localparam int NEWER_LEN = WINDOW - HALF;

  localparam int SAMPLE_W  = 10;
  localparam int PCT_W     = 10;
  localparam int DIR_W     = 2;

  localparam int IDX_W     = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int FILL_W    = $clog2(WINDOW + 1);

  // summed deltas of one half, magnitude and signed widths
  localparam int MAG_W     = $clog2(((1 << SAMPLE_W) - 1) * NEWER_LEN + 1);
  localparam int ACC_W     = MAG_W + 1;
  localparam int DIV_W     = $clog2(NEWER_LEN + 1);

  // reciprocal of each half length, exact floor for any magnitude below 2**MAG_W
  localparam int RECIP_SH  = MAG_W + DIV_W;
  localparam int RECIP_W   = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP_OLDER =
    RECIP_W'(((1 << RECIP_SH) + HALF - 1) / HALF);
  localparam logic [RECIP_W-1:0] RECIP_NEWER =
    RECIP_W'(((1 << RECIP_SH) + NEWER_LEN - 1) / NEWER_LEN);

  localparam int PCT_SCALE   = 100;
  localparam int SCALE_W     = 7;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // configuration register indexes
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_PERCENT   = 1'b1;

  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(40);

endpackage

### src/wct_cell.sv
// One window cell: holds a sample and passes it to its neighbor on shift.
module wct_cell (
  input  logic                            clk,
  input  logic                            shift,
  input  logic [wct_pkg::SAMPLE_W-1:0]    d,
  output logic [wct_pkg::SAMPLE_W-1:0]    q
);
  import wct_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

### src/wct_divider.sv
// Signed divide by a constant half length via reciprocal multiply, truncated toward zero.
module wct_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [wct_pkg::ACC_W-1:0]  dividend,
  input  logic [wct_pkg::RECIP_W-1:0]       recip,
  output logic signed [wct_pkg::ACC_W-1:0]  quotient,
  output logic                              done
);
  import wct_pkg::*;

  logic [ACC_W-1:0]         dividend_abs;
  logic [MAG_W+RECIP_W-1:0] prod;
  logic [MAG_W-1:0]         qmag;

  assign dividend_abs = dividend[ACC_W-1] ? ACC_W'(-dividend) : dividend;
  assign prod         = dividend_abs[MAG_W-1:0] * recip;
  assign qmag         = prod[RECIP_SH +: MAG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        quotient <= dividend[ACC_W-1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      end
    end
  end

endmodule

### src/window_change_trigger_top.sv
// Top level of the window change trigger: cell chain, walk, dividers, decision.
//
// One sample word in gives one result word out. While the window is still
// filling, a word reports zeros. Once full, the cell chain is rotated once,
// one cell per cycle, to sum each half's deltas, and the two half sums are
// then divided by their lengths in one registered reciprocal multiply, after
// which the averages are loaded and the result presented. A new sample is
// taken only when the block is idle; a finished result may wait in the
// output register while the next sample is accepted.
module window_change_trigger_top (
  input  logic                               clk,
  input  logic                               rst,
  // sample [9:0]
  input  logic [wct_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // window_full [0], triggered [1], older_average [11:2], newer_average [21:12]
  output logic [wct_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [wct_pkg::PCT_W-1:0]          cfg_data
);
  import wct_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0]          state;
  logic [IDX_W-1:0]    idx;
  logic [FILL_W-1:0]   fill;
  logic                full_flag;
  logic [DIR_W-1:0]    direction;
  logic [PCT_W-1:0]    percent_threshold;

  logic                accept;
  logic                walking;
  logic                shift;
  logic [SAMPLE_W-1:0] chain [WINDOW];
  logic [SAMPLE_W-1:0] tail_d;
  logic [SAMPLE_W-1:0] head;

  logic [SAMPLE_W-1:0]     base_o;
  logic [SAMPLE_W-1:0]     base_n;
  logic signed [ACC_W-1:0] acc_o;
  logic signed [ACC_W-1:0] acc_n;
  logic signed [ACC_W-1:0] diff_o;
  logic signed [ACC_W-1:0] diff_n;

  logic                    div_start;
  logic signed [ACC_W-1:0] q_o;
  logic signed [ACC_W-1:0] q_n;
  logic                    div_done_o;
  logic                    div_done_n;
  logic [ACC_W:0]          sum_o;
  logic [ACC_W:0]          sum_n;
  logic [SAMPLE_W-1:0]     older_avg;
  logic [SAMPLE_W-1:0]     newer_avg;

  logic signed [SAMPLE_W:0] change;
  logic [SAMPLE_W:0]        change_abs;
  logic [SAMPLE_W-1:0]      magnitude;
  logic [SAMPLE_W+SCALE_W-1:0] lhs;
  logic [SAMPLE_W+PCT_W-1:0]   rhs;
  logic                     meets;
  logic                     fire;
  logic                     out_free;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign walking  = (state == ST_WALK);
  assign shift    = accept || walking;
  assign head     = chain[0];
  assign tail_d   = walking ? head : s_tdata[SAMPLE_W-1:0];
  assign out_free = !m_tvalid || m_tready;

  // chain[0] is the oldest sample, chain[WINDOW-1] the newest
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == WINDOW - 1) begin : g_tail
      wct_cell u_cell (.clk(clk), .shift(shift), .d(tail_d), .q(chain[i]));
    end else begin : g_body
      wct_cell u_cell (.clk(clk), .shift(shift), .d(chain[i+1]), .q(chain[i]));
    end
  end

  assign diff_o = ACC_W'($signed({1'b0, head}) - $signed({1'b0, base_o}));
  assign diff_n = ACC_W'($signed({1'b0, head}) - $signed({1'b0, base_n}));

  always_ff @(posedge clk) begin
    if (rst) begin
      direction         <= '0;
      percent_threshold <= PCT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION: direction         <= cfg_data[DIR_W-1:0];
        REG_PERCENT:   percent_threshold <= cfg_data;
        default:       ;
      endcase
    end
  end

  wct_divider u_div_older (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_o),
    .recip    (RECIP_OLDER),
    .quotient (q_o),
    .done     (div_done_o)
  );

  wct_divider u_div_newer (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_n),
    .recip    (RECIP_NEWER),
    .quotient (q_n),
    .done     (div_done_n)
  );

  assign sum_o = {{(ACC_W + 1 - SAMPLE_W){1'b0}}, base_o} + {q_o[ACC_W-1], q_o};
  assign sum_n = {{(ACC_W + 1 - SAMPLE_W){1'b0}}, base_n} + {q_n[ACC_W-1], q_n};

  assign change     = $signed({1'b0, newer_avg}) - $signed({1'b0, older_avg});
  assign change_abs = change[SAMPLE_W] ? (SAMPLE_W + 1)'(-change) : change;
  assign magnitude  = change_abs[SAMPLE_W-1:0];
  assign lhs        = magnitude * SCALE_W'(PCT_SCALE);
  assign rhs        = older_avg * percent_threshold;
  assign meets      = {{(PCT_W - SCALE_W){1'b0}}, lhs} >= rhs;

  always_comb begin
    fire = 1'b0;
    if (meets) begin
      if (direction[DIR_W-1]) begin
        fire = change[SAMPLE_W];
      end else if (direction[0]) begin
        fire = (change != '0) && !change[SAMPLE_W];
      end else begin
        fire = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      full_flag <= 1'b0;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
      idx       <= '0;
    end else begin
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            idx <= '0;
            if (fill >= FILL_W'(WINDOW - 1)) begin
              fill      <= FILL_W'(WINDOW);
              full_flag <= 1'b1;
              state     <= ST_WALK;
            end else begin
              fill      <= fill + 1'b1;
              full_flag <= 1'b0;
              older_avg <= '0;
              newer_avg <= '0;
              state     <= ST_FINAL;
            end
          end
        end
        ST_WALK: begin
          if (idx == '0) begin
            base_o <= head;
            acc_o  <= '0;
          end else if (idx < IDX_W'(HALF)) begin
            acc_o <= acc_o + diff_o;
          end else if (idx == IDX_W'(HALF)) begin
            base_n <= head;
            acc_n  <= '0;
          end else begin
            acc_n <= acc_n + diff_n;
          end
          idx <= idx + 1'b1;
          if (idx == IDX_W'(WINDOW - 1)) begin
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done_o) begin
            older_avg <= sum_o[SAMPLE_W-1:0];
            newer_avg <= sum_n[SAMPLE_W-1:0];
            state     <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_TDATA_W - 2 - 2 * SAMPLE_W){1'b0}}, newer_avg, older_avg,
                         full_flag && fire, full_flag};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_done_o |-> div_done_n)
    else $error("older and newer dividers out of step");

  a_not_full_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[2*SAMPLE_W+1:1] == '0))
    else $error("result before window full carries nonzero fields");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("sample accepted while previous one still in work");

endmodule

### tb/window_change_trigger_top_tb.sv
// Testbench for window_change_trigger_top: streamed samples against a scoreboard predictor.
`timescale 1ns / 100ps

module window_change_trigger_top_tb;
  import wct_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int RST_CYCLES = 10;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 40;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 110;

  localparam logic [DIR_W-1:0] DIR_ANY      = 2'b00;
  localparam logic [DIR_W-1:0] DIR_RISE     = 2'b01;
  localparam logic [DIR_W-1:0] DIR_FALL     = 2'b11;
  localparam logic [DIR_W-1:0] DIR_FALL_ALT = 2'b10;

  typedef enum {SEG_NOISE, SEG_FLAT, SEG_WOBBLE, SEG_LOW, SEG_RAIL} seg_kind_t;

  typedef struct {
    logic                full;
    logic                fired;
    logic [SAMPLE_W-1:0] older;
    logic [SAMPLE_W-1:0] newer;
  } change_result_t;

  class change_scoreboard;
    logic [SAMPLE_W-1:0] win [WINDOW];
    int                  next_slot;
    int                  held;
    int                  dir_val;
    logic [PCT_W-1:0]    thr;
    change_result_t      pending_q [$];
    int                  errors;

    function new();
      next_slot = 0;
      held      = 0;
      dir_val   = 0;
      thr       = PCT_RESET;
      errors    = 0;
    endfunction

    function void write_reg(logic idx, logic [PCT_W-1:0] val);
      if (idx == REG_DIRECTION)
        dir_val = val[1] ? int'(val[1:0]) - 4 : int'(val[1:0]);
      else
        thr = val;
    endfunction

    function int half_avg(int first, int len);
      int pos;
      int base;
      int deltas;
      pos    = (next_slot + first) % WINDOW;
      base   = int'(win[pos]);
      deltas = 0;
      for (int i = 0; i < len; i++) begin
        deltas += int'(win[pos]) - base;
        pos = (pos + 1) % WINDOW;
      end
      return base + deltas / len;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      change_result_t r;
      int older;
      int newer;
      int change;
      int mag;
      win[next_slot] = s;
      next_slot = (next_slot + 1) % WINDOW;
      if (held < WINDOW) held++;
      r = '{1'b0, 1'b0, '0, '0};
      if (held == WINDOW) begin
        older  = half_avg(0, HALF);
        newer  = half_avg(HALF, NEWER_LEN);
        change = newer - older;
        mag    = (change < 0) ? -change : change;
        r.full  = 1'b1;
        r.older = older[SAMPLE_W-1:0];
        r.newer = newer[SAMPLE_W-1:0];
        if (mag * PCT_SCALE >= older * int'(thr)) begin
          if (dir_val == 0)     r.fired = 1'b1;
          else if (dir_val > 0) r.fired = (change > 0);
          else                  r.fired = (change < 0);
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] w);
      change_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result word %h", w);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (w[0] !== e.full) begin
        $error("window_full: expected %0d, got %0d", e.full, w[0]);
        errors++;
      end
      if (w[1] !== e.fired) begin
        $error("triggered: expected %0d, got %0d", e.fired, w[1]);
        errors++;
      end
      if (w[11:2] !== e.older) begin
        $error("older_average: expected %0d, got %0d", e.older, w[11:2]);
        errors++;
      end
      if (w[21:12] !== e.newer) begin
        $error("newer_average: expected %0d, got %0d", e.newer, w[21:12]);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [PCT_W-1:0]       cfg_data;

  change_scoreboard sb = new();
  bit               quiet;
  int               cycles;
  seg_kind_t        seg_kind;
  int               seg_left;
  int               seg_level;

  window_change_trigger_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] next_sample();
    int v;
    if (seg_left == 0) begin
      seg_kind  = seg_kind_t'($urandom_range(0, 4));
      seg_left  = $urandom_range(3, 15);
      seg_level = $urandom_range(0, 1023);
    end
    seg_left--;
    // occasional step inside a segment
    if (seg_left == 4 && $urandom_range(0, 1)) seg_level = $urandom_range(0, 1023);
    case (seg_kind)
      SEG_NOISE:  v = $urandom_range(0, 1023);
      SEG_FLAT:   v = seg_level;
      SEG_WOBBLE: v = seg_level + int'($urandom_range(0, 16)) - 8;
      SEG_LOW:    v = $urandom_range(0, 15);
      default:    v = $urandom_range(0, 1) ? 1023 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_word(input logic [SAMPLE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {{(IN_TDATA_W-SAMPLE_W){1'b0}}, v};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(v);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [PCT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // result side ready with random stalls
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("window_change_trigger_top verification failed");
      $finish;
    end
  end

  initial begin
    logic [DIR_W-1:0] plan_dir [PHASES];
    logic [PCT_W-1:0] plan_thr [PHASES];
    quiet     = 1'b0;
    seg_left  = 0;
    seg_level = 0;
    seg_kind  = SEG_NOISE;
    rst       <= 1'b1;
    s_tdata   <= '0;
    s_tvalid  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_DIRECTION;
    cfg_data  <= '0;
    plan_dir = '{DIR_RISE, DIR_FALL, DIR_FALL_ALT, DIR_ANY, DIR_ANY,
                 DIR_RISE, DIR_FALL, DIR_ANY, DIR_RISE, DIR_FALL};
    plan_thr = '{10'd0, 10'd40, 10'd0, 10'd1000, 10'd1023,
                 10'd1023, 10'd1000, 10'd0, 10'd0, 10'd0};
    for (int p = 7; p < PHASES; p++) plan_thr[p] = PCT_W'($urandom_range(1, 200));
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: flat zeros fire on a zero change, then rail steps
    for (int i = 0; i < 10; i++) send_word(10'd0);
    for (int i = 0; i < 10; i++) send_word(10'd1023);
    for (int i = 0; i < 5; i++) send_word(10'd0);

    for (int p = 0; p < PHASES; p++) begin
      s_tvalid <= 1'b0;
      drain();
      quiet = (p % 4 == 1);
      write_reg(REG_DIRECTION, {PCT_W'($urandom) >> DIR_W << DIR_W} | PCT_W'(plan_dir[p]));
      write_reg(REG_PERCENT, plan_thr[p]);
      for (int i = 0; i < PHASE_LEN; i++) send_word(next_sample());
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("window_change_trigger_top verification clean");
    end else begin
      $display("window_change_trigger_top verification failed");
    end
    $finish;
  end

endmodule
